[rtl/bba_pkg.sv]
// ----------------------------------------------------------------------------
// bba_pkg: shared constants and types for the bitmap block allocator
// map geometry, operation codes and derived widths
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int unsigned Blocks      = 4096;
  localparam int unsigned BlockBytes  = 4096;
  localparam int unsigned WordW       = 32;
  localparam int unsigned Words       = Blocks / WordW;
  localparam int unsigned WordAw      = $clog2(Words);
  localparam int unsigned BitAw       = $clog2(WordW);
  localparam int unsigned BlkAw       = $clog2(Blocks);
  localparam int unsigned CntW        = 13;
  localparam int unsigned KbW         = 22;
  localparam int unsigned AddrW       = 32;
  localparam int unsigned BaddrW      = 24;
  localparam int unsigned ShiftBytes  = $clog2(BlockBytes);
  localparam int unsigned Reserved    = (1024 * 1024) / BlockBytes;
  localparam int unsigned KbShift     = $clog2(BlockBytes / 1024);
  localparam logic [KbW-1:0] MemKbReset = KbW'(16384);

  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

endpackage

[rtl/bba_ram.sv]
// ----------------------------------------------------------------------------
// bba_ram: generic single-port-write, single-read ram
// registered read data; the read port adds register latency
// ----------------------------------------------------------------------------
module bba_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/bitmap_block_allocator.sv]
// ----------------------------------------------------------------------------
// bitmap_block_allocator: first-fit page allocator over a used-block bitmap
// the map sits in a 128 x 32 ram; init, alloc and free sweep it word by word
// ----------------------------------------------------------------------------
// channel   | dir | contents
// s_axis    | in  | tdata {address[46:15], count[14:2], op[1:0]}
// m_axis    | out | tdata {free[50:38], used[37:25], baddr[24:1], ok[0]}
// mem_size  | in  | write enable + 22 bit data
// init sweeps every word of the map; free sweeps the words it touches.
// alloc searches word by word, then makes a second pass marking the run.
// the ram read-modify-write sets the pace. after reset a clearing pass
// runs before the first request is taken. results wait in an output
// register; a new request is taken once the block is idle and the output
// register is empty.
// ----------------------------------------------------------------------------
module bitmap_block_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [21:0] cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,  // op[1:0] count[14:2] address[46:15]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [55:0] m_axis_tdata_o   // ok[0] baddr[24:1] used[37:25] free[50:38]
);
  import bba_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_RD    = 6'b000010,
    ST_MOD   = 6'b000100,
    ST_MARK  = 6'b001000,
    ST_MMOD  = 6'b010000,
    ST_DONE  = 6'b100000
  } st_e;

  st_e              st_q, st_d;
  op_e              op_q, op_d;
  logic [KbW-1:0]   kb_q;
  logic [CntW-1:0]  used_q, used_d, bcnt_q, bcnt_d;
  logic [CntW-1:0]  run_q, run_d;
  logic [CntW-1:0]  need_q, need_d;
  logic [BlkAw:0]   blk_q, blk_d;          // first block of a free request
  logic [BlkAw:0]   first_q, first_d;
  logic [BlkAw:0]   lim_q, lim_d;          // stop block (exclusive)
  logic [WordAw:0]  w_q, w_d;
  logic             ok_q, ok_d, fnd_q, fnd_d;
  logic             ov_q, ov_d;
  logic [55:0]      out_q, out_d;

  logic             we;
  logic [WordAw-1:0] waddr, raddr;
  logic [WordW-1:0] wdata, rdata;

  bba_ram #(.Width(WordW), .Depth(Words)) u_map (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  // init word content: reserved bits set below min(reserved, bcnt)
  logic [BlkAw:0] resv_lim;
  always_comb begin
    resv_lim = (bcnt_q < CntW'(Reserved)) ? (BlkAw+1)'(bcnt_q) : (BlkAw+1)'(Reserved);
  end

  // block count from kb
  logic [KbW-1:0] kb_blk;
  logic [CntW-1:0] new_bcnt;
  always_comb begin
    kb_blk = kb_q >> KbShift;
    new_bcnt = (kb_blk > KbW'(Blocks)) ? CntW'(Blocks) : CntW'(kb_blk);
  end

  // per-word combinational processing
  logic [WordW-1:0] mw;
  logic [CntW-1:0]  r;
  logic [BlkAw:0]   base, b;
  logic             hit;
  logic [BlkAw:0]   hitfirst;
  logic [5:0]       cleared;
  logic [WordW-1:0] busy, clr;
  logic             any_set;
  logic [BitAw-1:0] last_set;
  logic [CntW-1:0]  run_i;
  always_comb begin
    mw = rdata;
    r = run_q;
    hit = 1'b0;
    hitfirst = '0;
    cleared = '0;
    busy = '0;
    clr = '0;
    any_set = 1'b0;
    last_set = '0;
    run_i = '0;
    base = {1'b0, w_q[WordAw-1:0], {BitAw{1'b0}}};
    b = '0;
    unique case (st_q)
      ST_MOD: begin
        if (op_q == OP_INIT) begin
          for (int i = 0; i < WordW; i++) begin
            b = base + (BlkAw+1)'(i);
            mw[i] = (b < resv_lim);
          end
        end else if (op_q == OP_ALLOC) begin
          // blocks past the count act as used so no run reaches them
          for (int i = 0; i < WordW; i++) begin
            b = base + (BlkAw+1)'(i);
            busy[i] = rdata[i] || (b >= (BlkAw+1)'(bcnt_q));
          end
          // run ending at each bit: distance to the nearest used bit at or
          // below it, else the carried run plus the free bits so far
          for (int i = 0; i < WordW; i++) begin
            any_set = 1'b0;
            last_set = '0;
            for (int j = 0; j <= i; j++) begin
              if (busy[j]) begin
                any_set = 1'b1;
                last_set = BitAw'(j);
              end
            end
            run_i = any_set ? CntW'(BitAw'(i) - last_set) : run_q + CntW'(i + 1);
            if (!hit && run_i == need_q) begin
              hit = 1'b1;
              hitfirst = base + (BlkAw+1)'(i) + 1'b1 - (BlkAw+1)'(need_q);
            end
          end
          r = run_i;
        end else begin
          for (int i = 0; i < WordW; i++) begin
            b = base + (BlkAw+1)'(i);
            clr[i] = (b >= blk_q) && (b < lim_q) && rdata[i];
          end
          mw = rdata & ~clr;
          cleared = 6'($countones(clr));
        end
      end
      ST_MMOD: begin
        for (int i = 0; i < WordW; i++) begin
          b = base + (BlkAw+1)'(i);
          if (b >= first_q && b < lim_q) mw[i] = 1'b1;
        end
      end
      default: ;
    endcase
  end

  logic [BlkAw:0] in_blk;
  logic [AddrW-1:0] in_addr;
  logic [CntW-1:0] in_cnt;
  logic [AddrW-ShiftBytes-1:0] in_idx;
  logic [AddrW-ShiftBytes:0] lim_free;
  always_comb begin
    in_addr = s_axis_tdata_i[46:15];
    in_cnt  = s_axis_tdata_i[14:2];
    in_idx  = in_addr[AddrW-1:ShiftBytes];
    lim_free = {1'b0, in_idx} + (AddrW-ShiftBytes+1)'(in_cnt);
    in_blk = (in_idx > (AddrW-ShiftBytes)'(Blocks)) ? (BlkAw+1)'(Blocks)
                                                   : (BlkAw+1)'(in_idx);
  end

  logic accept;
  assign s_axis_tready_o = (st_q == ST_IDLE) && !ov_q && !m_axis_tvalid_o;
  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    st_d = st_q; op_d = op_q; used_d = used_q; bcnt_d = bcnt_q;
    run_d = run_q; need_d = need_q; blk_d = blk_q; first_d = first_q;
    lim_d = lim_q; w_d = w_q; ok_d = ok_q; fnd_d = fnd_q; ov_d = ov_q;
    out_d = out_q;
    we = 1'b0; waddr = w_q[WordAw-1:0]; wdata = mw;
    raddr = w_q[WordAw-1:0];
    unique case (st_q)
      ST_IDLE: begin
        if (ov_q) begin
          ov_d = 1'b0;
          out_d = {5'd0, bcnt_q - used_q, used_q, 24'd0, ok_q};
        end else if (accept) begin
          op_d = op_e'(s_axis_tdata_i[1:0]);
          need_d = in_cnt;
          run_d = '0;
          w_d = '0;
          ok_d = 1'b1;
          fnd_d = 1'b0;
          unique case (op_e'(s_axis_tdata_i[1:0]))
            OP_INIT: begin
              bcnt_d = new_bcnt;
              used_d = (new_bcnt < CntW'(Reserved)) ? new_bcnt : CntW'(Reserved);
              st_d = ST_RD;
            end
            OP_ALLOC: begin
              if (in_cnt == '0 || in_cnt > bcnt_q) begin
                ok_d = 1'b0; ov_d = 1'b1;
              end else st_d = ST_RD;
            end
            OP_FREE: begin
              blk_d = in_blk;
              lim_d = (lim_free > (AddrW-ShiftBytes+1)'(bcnt_q)) ? (BlkAw+1)'(bcnt_q)
                                                               : (BlkAw+1)'(lim_free);
              w_d = (WordAw+1)'(in_blk >> BitAw);
              if (in_blk >= (BlkAw+1)'(bcnt_q) || in_cnt == '0) ov_d = 1'b1;
              else st_d = ST_RD;
            end
            default: begin
              ok_d = 1'b0; ov_d = 1'b1;
            end
          endcase
        end
      end
      ST_RD: st_d = ST_MOD;
      ST_MOD: begin
        w_d = w_q + 1'b1;
        st_d = ST_RD;
        unique case (op_q)
          OP_INIT: begin
            we = 1'b1;
            if (w_q == (WordAw+1)'(Words-1)) st_d = ST_DONE;
          end
          OP_ALLOC: begin
            run_d = r;
            if (hit) begin
              first_d = hitfirst;
              lim_d = hitfirst + (BlkAw+1)'(need_q);
              w_d = (WordAw+1)'(hitfirst >> BitAw);
              used_d = used_q + need_q;
              st_d = ST_MARK;
            end else if (w_q == (WordAw+1)'(Words-1)) begin
              ok_d = 1'b0; st_d = ST_DONE;
            end
          end
          default: begin
            we = 1'b1;
            used_d = used_q - CntW'(cleared);
            if (base + (BlkAw+1)'(WordW) >= lim_q)
              st_d = ST_DONE;
          end
        endcase
      end
      ST_MARK: st_d = ST_MMOD;
      ST_MMOD: begin
        we = 1'b1;
        w_d = w_q + 1'b1;
        fnd_d = 1'b1;
        if (base + (BlkAw+1)'(WordW) >= lim_q)
          st_d = ST_DONE;
        else st_d = ST_MARK;
      end
      ST_DONE: begin
        st_d = ST_IDLE;
        out_d = {5'd0, bcnt_q - used_q, used_q,
                 fnd_q ? BaddrW'(32'(first_q) << ShiftBytes) : 24'd0, ok_q};
      end
      default: st_d = ST_IDLE;
    endcase
  end

  logic vld_q, vld_d;
  always_comb begin
    vld_d = vld_q;
    if (m_axis_tready_i) vld_d = 1'b0;
    if ((st_q == ST_DONE) || (st_q == ST_IDLE && ov_q)) vld_d = 1'b1;
  end

  // reset clear pass reuses init
  logic rst_init_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_RD; op_q <= OP_INIT; used_q <= CntW'(Reserved);
      bcnt_q <= CntW'(Blocks); ov_q <= 1'b0; vld_q <= 1'b0; w_q <= '0;
      kb_q <= MemKbReset; rst_init_q <= 1'b1; ok_q <= 1'b1; fnd_q <= 1'b0;
    end else begin
      if (cfg_we_i) kb_q <= cfg_wdata_i;
      op_q <= op_d; used_q <= used_d; bcnt_q <= bcnt_d; w_q <= w_d;
      ok_q <= ok_d; fnd_q <= fnd_d; ov_q <= ov_d;
      if (rst_init_q && st_q == ST_DONE) begin
        rst_init_q <= 1'b0; st_q <= ST_IDLE; vld_q <= vld_q;
      end else begin
        st_q <= st_d; vld_q <= vld_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    run_q <= run_d; need_q <= need_d; blk_q <= blk_d;
    first_q <= first_d; lim_q <= lim_d;
    if (!(rst_init_q && st_q == ST_DONE)) out_q <= out_d;
  end

  assign m_axis_tvalid_o = vld_q;
  assign m_axis_tdata_o = out_q;

  a_used_le_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= bcnt_q) else $error("used exceeds block count");
  a_busy_no_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != ST_IDLE) |-> !s_axis_tready_o) else $error("ready while busy");
  a_done_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_DONE && !rst_init_q) |=> m_axis_tvalid_o) else $error("lost result");

endmodule

[tb/tb_bitmap_block_allocator.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bitmap_block_allocator: self-checking bench for the page allocator
// a local bitmap predicts each request's result; results are compared field by
// field against a queue of expected results, with random stalls on both sides
// ----------------------------------------------------------------------------
module tb_bitmap_block_allocator;
  import bba_pkg::*;

  localparam int unsigned WdogLimit = 200000;

  // lowest field last: ok sits in bit 0 of the result bus
  typedef struct packed {
    logic [12:0]     free;
    logic [12:0]     used;
    logic [23:0]     baddr;
    logic            ok;
  } alloc_rsp_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [21:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [47:0] s_axis_tdata_i = '0;   // op, count, address
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [55:0] m_axis_tdata_o;        // ok, baddr, used, free

  // predictor state
  logic        page_map [Blocks];
  int unsigned pages_used;
  int unsigned pages_total;
  logic [21:0] mem_kb;

  alloc_rsp_t  rsp_q [$];
  int unsigned errors = 0;
  int unsigned idle_cycles = 0;
  bit          idle_on = 1'b1;
  bit          hold_rx = 1'b0;

  bitmap_block_allocator u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic void map_reinit();
    longint unsigned nb;
    nb = (longint'(mem_kb) * 1024) / BlockBytes;
    if (nb > Blocks) nb = Blocks;
    pages_total = 32'(nb);
    pages_used = 0;
    for (int i = 0; i < Blocks; i++) page_map[i] = 1'b0;
    for (int i = 0; i < Reserved && i < pages_total; i++) begin
      page_map[i] = 1'b1;
      pages_used++;
    end
  endfunction

  function automatic alloc_rsp_t predict_page_op(op_e op, int unsigned n,
                                                 logic [31:0] addr);
    alloc_rsp_t r;
    int unsigned run;
    longint unsigned idx;
    r = '0;
    case (op)
      OP_INIT: begin
        map_reinit();
        r.ok = 1'b1;
      end
      OP_ALLOC: begin
        run = 0;
        if (n != 0 && n <= pages_total) begin
          for (int j = 0; j < pages_total; j++) begin
            if (page_map[j]) begin
              run = 0;
            end else begin
              run++;
              if (run == n) begin
                for (int k = j + 1 - n; k <= j; k++) page_map[k] = 1'b1;
                pages_used += n;
                r.ok = 1'b1;
                r.baddr = 24'((j + 1 - n) * BlockBytes);
                break;
              end
            end
          end
        end
      end
      OP_FREE: begin
        idx = addr / BlockBytes;
        for (longint unsigned i = 0; i < n && idx + i < pages_total; i++) begin
          if (page_map[idx + i]) begin
            page_map[idx + i] = 1'b0;
            if (pages_used > 0) pages_used--;
          end
        end
        r.ok = 1'b1;
      end
      default: ;
    endcase
    r.used = 13'(pages_used);
    r.free = 13'(pages_total - pages_used);
    return r;
  endfunction

  task automatic send_request(op_e op, int unsigned n, logic [31:0] addr);
    while (idle_on && $urandom_range(99) < 14) @(posedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {1'b0, addr, n[12:0], op};
    rsp_q.push_back(predict_page_op(op, n, addr));
    do @(posedge clk_i); while (!s_axis_tready_o);
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (rsp_q.size() != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
  endtask

  task automatic write_mem_kb(logic [21:0] kb);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= kb;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    mem_kb = kb;
  endtask

  // receiver side
  always @(posedge clk_i) begin
    if (rst_ni) m_axis_tready_i <= !hold_rx && !(idle_on && $urandom_range(99) < 14);
  end

  always @(posedge clk_i) begin
    alloc_rsp_t got, want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = alloc_rsp_t'(m_axis_tdata_o[50:0]);
      if (rsp_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = rsp_q.pop_front();
        if (got.ok !== want.ok) begin
          $display("%0t: ok exp %0d got %0d", $time, want.ok, got.ok); errors++;
        end
        if (got.baddr !== want.baddr) begin
          $display("%0t: baddr exp %h got %h", $time, want.baddr, got.baddr); errors++;
        end
        if (got.used !== want.used) begin
          $display("%0t: used exp %0d got %0d", $time, want.used, got.used); errors++;
        end
        if (got.free !== want.free) begin
          $display("%0t: free exp %0d got %0d", $time, want.free, got.free); errors++;
        end
      end
    end
  end

  // watchdog on accept activity
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)
        || hold_rx)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WdogLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic test_directed();
    send_request(OP_ALLOC, 0, 0);
    send_request(OP_ALLOC, 4097, 0);
    send_request(OP_ALLOC, 8191, 0);
    send_request(OP_ALLOC, 1, 0);
    send_request(OP_ALLOC, 3840, 0);
    send_request(OP_ALLOC, 1, 0);
    send_request(OP_FREE, 1, 32'h0010_0000);
    send_request(OP_FREE, 1, 32'h0010_0000);
    send_request(OP_FREE, 8191, 32'hFFFF_FFFF);
    send_request(OP_FREE, 10, 32'h00FF_F000);
    send_request(OP_FREE, 4096, 0);
    send_request(OP_ALLOC, 4096, 0);
    send_request(OP_NONE, 8191, 32'hFFFF_FFFF);
    send_request(OP_INIT, 0, 0);
    send_request(OP_ALLOC, 3840, 0);
    send_request(OP_FREE, 4096, 32'h00FF_F000);
  endtask

  task automatic test_random(int unsigned items);
    int unsigned sel, n;
    logic [31:0] a;
    for (int i = 0; i < items; i++) begin
      sel = $urandom_range(99);
      n = ($urandom_range(9) == 0) ? $urandom_range(8191) : $urandom_range(64);
      a = ($urandom_range(9) == 0) ? $urandom() : 32'($urandom_range(4095)) << 12;
      if (sel < 45)      send_request(OP_ALLOC, n, a);
      else if (sel < 90) send_request(OP_FREE, n, a);
      else if (sel < 95) send_request(OP_INIT, n, a);
      else               send_request(OP_NONE, n, a);
    end
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_rx = 1'b1;
        repeat (3000) @(posedge clk_i);
        hold_rx = 1'b0;
      end
      test_random(12);
    join
  endtask

  task automatic test_mem_sizes();
    logic [21:0] sizes [5] = '{22'd0, 22'd1023, 22'd2048, 22'd4194303, 22'd16384};
    foreach (sizes[i]) begin
      write_mem_kb(sizes[i]);
      send_request(OP_INIT, 0, 0);
      send_request(OP_ALLOC, 1, 0);
      send_request(OP_FREE, 4096, 0);
      test_random(40);
    end
  endtask

  initial begin
    mem_kb = MemKbReset;
    map_reinit();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_backpressure();
    idle_on = 1'b0;
    test_random(100);
    idle_on = 1'b1;
    test_mem_sizes();
    test_random(300);
    wait_drained();
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
